/* rtl/core/tempo_synced_loop_playhead_defines.svh */
// assertion macros shared by the playhead rtl
`ifndef TEMPO_SYNCED_LOOP_PLAYHEAD_DEFINES_SVH
`define TEMPO_SYNCED_LOOP_PLAYHEAD_DEFINES_SVH

// same-cycle implication, off during reset
`define TSLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define TSLP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// invariant on every clock
`define TSLP_ASSERT_ALW(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

/* rtl/core/tslp_pkg.sv */
// types, constants and codes shared by the loop playhead modules
`default_nettype none

package tslp_pkg;

  localparam int FRAME_BITS      = 28;
  localparam int MAX_FRAMES_DEF  = 16;
  localparam int COUNT_BITS_DEF  = 24;
  localparam int TEMPO_BITS      = 25;
  localparam int GAIN_BITS       = 16;
  localparam int PADDR_BITS      = 5;

  localparam int DIV_DEN_W = 40;
  localparam int DIV_Q_W   = 32;
  localparam int DIV_NUM_W = DIV_DEN_W + DIV_Q_W;

  localparam logic [GAIN_BITS-1:0]  UNITY       = 16'd32768;
  localparam logic [TEMPO_BITS-1:0] TEMPO_RESET = 25'(120 << 16);
  localparam logic [31:0]           MEAS_LO     = 32'(20 << 16);
  localparam logic [31:0]           MEAS_HI     = 32'(400 << 16);
  // ceil(2^37 / 100): (x * DIV100_MAGIC) >> 37 is x / 100 for any 32-bit x
  localparam logic [31:0]           DIV100_MAGIC = 32'h51EB851F;

  typedef enum logic [2:0] {
    REG_LOOP_LENGTH   = 3'd0,
    REG_RATE_RATIO    = 3'd1,
    REG_OUTPUT_RATE   = 3'd2,
    REG_FALLBACK_BARS = 3'd3,
    REG_FADE_IN_STEP  = 3'd4,
    REG_FADE_OUT_STEP = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [27:0] loop_length;
    logic [31:0] rate_ratio;
    logic [17:0] output_rate;
    logic [7:0]  fallback_bars;
    logic [15:0] fade_in_step;
    logic [15:0] fade_out_step;
  } cfg_t;

  typedef struct packed {
    logic        clock_high;
    logic        trigger_high;
    logic        reset_pressed;
    logic        cue_switch;
    logic        sync_switch;
    logic [4:0]  bars_knob;
    logic [3:0]  shift_beat;
    logic [16:0] speed_factor;
    logic [11:0] frames_ready;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  frames_to_take;
    logic        seek_now;
    logic [27:0] seek_frame;
    logic [27:0] play_frame;
    logic [15:0] out_gain;
    logic        route_to_cue;
    logic        muted;
  } out_item_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_FRONT,
    S_PREP,
    S_PREP2,
    S_TGT_GO,
    S_TGT_WAIT,
    S_MEAS_GO,
    S_MEAS_WAIT,
    S_SMOOTH_PREP,
    S_SMOOTH_GO,
    S_SEL_SPEED,
    S_MUL1,
    S_MUL2,
    S_SPEED_GO,
    S_SPEED_WAIT,
    S_ACCUM,
    S_TAKE,
    S_EMIT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    DIV_TGT,
    DIV_MEAS,
    DIV_SPEED
  } div_sel_e;

  typedef struct packed {
    logic     load;
    logic     front;
    logic     prep;
    logic     prep2;
    logic     div_start;
    div_sel_e div_sel;
    logic     tgt_cap;
    logic     meas_cap;
    logic     smooth_prep;
    logic     tempo_cap;
    logic     speed_free;
    logic     mul1;
    logic     mul2;
    logic     speed_zero;
    logic     speed_cap;
    logic     accum;
    logic     take_step;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic muted;
    logic meas_ok;
    logic in_range;
    logic sync_path;
    logic den_zero;
    logic take_go;
    logic div_done;
  } status_t;

endpackage

`default_nettype wire

/* rtl/core/tempo_synced_loop_playhead.sv */
// channel  | signals                            | word
// input    | in_valid / in_stall / in_data      | tslp_pkg::in_item_t, one per sample tick
// result   | out_valid / out_stall / out_data   | tslp_pkg::out_item_t, one per input word
// config   | psel penable pwrite paddr pwdata   | six registers at byte address 4*i
//
// each word runs the shared 32-step divider for the loop-end offset, once more for the
// tempo measure on a clock edge and once more for the synced speed, then takes frames,
// all before the next word is accepted
// tempo smoothing divides by 100 with a reciprocal multiply
// a muted word (no loop loaded) goes straight to the result
// synchronous active-low reset; no clearing pass
// the result register lets the next word be accepted while out_stall holds
`default_nettype none

module tempo_synced_loop_playhead #(
  parameter int MAX_FRAMES_PER_TICK = tslp_pkg::MAX_FRAMES_DEF,
  parameter int COUNT_BITS          = tslp_pkg::COUNT_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire tslp_pkg::in_item_t              in_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output tslp_pkg::out_item_t                  out_data,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [tslp_pkg::PADDR_BITS-1:0] paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  tslp_pkg::cfg_t     cfg_r, cfg_nxt;
  tslp_pkg::cmd_t     cmd;
  tslp_pkg::status_t  stat;
  tslp_pkg::reg_idx_e reg_idx;
  logic               wr_en;

  assign pready  = 1'b1;
  assign reg_idx = tslp_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en   = psel & penable & pwrite & pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        tslp_pkg::REG_LOOP_LENGTH:   cfg_nxt.loop_length   = pwdata[27:0];
        tslp_pkg::REG_RATE_RATIO:    cfg_nxt.rate_ratio    = pwdata;
        tslp_pkg::REG_OUTPUT_RATE:   cfg_nxt.output_rate   = pwdata[17:0];
        tslp_pkg::REG_FALLBACK_BARS: cfg_nxt.fallback_bars = pwdata[7:0];
        tslp_pkg::REG_FADE_IN_STEP:  cfg_nxt.fade_in_step  = pwdata[15:0];
        tslp_pkg::REG_FADE_OUT_STEP: cfg_nxt.fade_out_step = pwdata[15:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      tslp_pkg::REG_LOOP_LENGTH:   prdata = 32'(cfg_r.loop_length);
      tslp_pkg::REG_RATE_RATIO:    prdata = cfg_r.rate_ratio;
      tslp_pkg::REG_OUTPUT_RATE:   prdata = 32'(cfg_r.output_rate);
      tslp_pkg::REG_FALLBACK_BARS: prdata = 32'(cfg_r.fallback_bars);
      tslp_pkg::REG_FADE_IN_STEP:  prdata = 32'(cfg_r.fade_in_step);
      tslp_pkg::REG_FADE_OUT_STEP: prdata = 32'(cfg_r.fade_out_step);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.loop_length   <= '0;
      cfg_r.rate_ratio    <= 32'd15414067;
      cfg_r.output_rate   <= 18'd48000;
      cfg_r.fallback_bars <= '0;
      cfg_r.fade_in_step  <= 16'd1;
      cfg_r.fade_out_step <= 16'd7;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tslp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  tslp_dp #(
    .MAX_FRAMES_PER_TICK (MAX_FRAMES_PER_TICK),
    .COUNT_BITS          (COUNT_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

/* rtl/core/tslp_div.sv */
// shared restoring divider, one quotient bit per cycle, 32-bit saturating quotient
`default_nettype none

module tslp_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic [tslp_pkg::DIV_NUM_W-1:0] num,
  input  wire logic [tslp_pkg::DIV_DEN_W-1:0] den,
  output logic                                done,
  output logic [tslp_pkg::DIV_Q_W-1:0]        quo
);

  localparam int DW = tslp_pkg::DIV_DEN_W;
  localparam int QW = tslp_pkg::DIV_Q_W;
  localparam int CW = $clog2(QW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [QW-1:0] lo_r, lo_nxt;

  logic [DW:0]   rem2;
  logic [DW:0]   diff;
  logic          ge;

  assign rem2 = {rem_r, lo_r[QW-1]};
  assign diff = rem2 - {1'b0, den_r};
  assign ge   = rem2 >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    lo_nxt   = lo_r;
    if (start) begin
      den_nxt = den;
      // quotient would not fit: high part already reaches the divisor
      if (num[DW+QW-1:QW] >= den) begin
        lo_nxt   = '1;
        done_nxt = 1'b1;
      end else begin
        rem_nxt  = num[DW+QW-1:QW];
        lo_nxt   = num[QW-1:0];
        cnt_nxt  = CW'(QW);
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DW-1:0] : rem2[DW-1:0];
      lo_nxt  = {lo_r[QW-2:0], ge};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    lo_r  <= lo_nxt;
  end

  assign done = done_r;
  assign quo  = lo_r;

endmodule

`default_nettype wire

/* rtl/core/tslp_ctrl.sv */
// sequencer for one tick: front update, divides, speed, frame taking, output
`default_nettype none

`include "tempo_synced_loop_playhead_defines.svh"

module tslp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire tslp_pkg::status_t stat,
  output tslp_pkg::cmd_t         cmd
);

  tslp_pkg::ctrl_state_e state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tslp_pkg::S_IDLE:
        if (in_valid) begin
          state_nxt = stat.muted ? tslp_pkg::S_EMIT : tslp_pkg::S_FRONT;
        end
      tslp_pkg::S_FRONT:       state_nxt = tslp_pkg::S_PREP;
      tslp_pkg::S_PREP:        state_nxt = tslp_pkg::S_PREP2;
      tslp_pkg::S_PREP2:       state_nxt = tslp_pkg::S_TGT_GO;
      tslp_pkg::S_TGT_GO:      state_nxt = tslp_pkg::S_TGT_WAIT;
      tslp_pkg::S_TGT_WAIT:
        if (stat.div_done) begin
          state_nxt = stat.meas_ok ? tslp_pkg::S_MEAS_GO : tslp_pkg::S_SEL_SPEED;
        end
      tslp_pkg::S_MEAS_GO:     state_nxt = tslp_pkg::S_MEAS_WAIT;
      tslp_pkg::S_MEAS_WAIT:
        if (stat.div_done) begin
          state_nxt = tslp_pkg::S_SMOOTH_PREP;
        end
      tslp_pkg::S_SMOOTH_PREP:
        state_nxt = stat.in_range ? tslp_pkg::S_SMOOTH_GO : tslp_pkg::S_SEL_SPEED;
      tslp_pkg::S_SMOOTH_GO:   state_nxt = tslp_pkg::S_SEL_SPEED;
      tslp_pkg::S_SEL_SPEED:
        state_nxt = stat.sync_path ? tslp_pkg::S_MUL1 : tslp_pkg::S_ACCUM;
      tslp_pkg::S_MUL1:        state_nxt = tslp_pkg::S_MUL2;
      tslp_pkg::S_MUL2:
        state_nxt = stat.den_zero ? tslp_pkg::S_ACCUM : tslp_pkg::S_SPEED_GO;
      tslp_pkg::S_SPEED_GO:    state_nxt = tslp_pkg::S_SPEED_WAIT;
      tslp_pkg::S_SPEED_WAIT:
        if (stat.div_done) begin
          state_nxt = tslp_pkg::S_ACCUM;
        end
      tslp_pkg::S_ACCUM:       state_nxt = tslp_pkg::S_TAKE;
      tslp_pkg::S_TAKE:
        if (!stat.take_go) begin
          state_nxt = tslp_pkg::S_EMIT;
        end
      tslp_pkg::S_EMIT:
        if (out_free) begin
          state_nxt = tslp_pkg::S_IDLE;
        end
      default:                 state_nxt = tslp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.div_sel = tslp_pkg::DIV_TGT;
    unique case (state_r)
      tslp_pkg::S_IDLE:        cmd.load = in_valid;
      tslp_pkg::S_FRONT:       cmd.front = 1'b1;
      tslp_pkg::S_PREP:        cmd.prep = 1'b1;
      tslp_pkg::S_PREP2:       cmd.prep2 = 1'b1;
      tslp_pkg::S_TGT_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = tslp_pkg::DIV_TGT;
      end
      tslp_pkg::S_TGT_WAIT:    cmd.tgt_cap = stat.div_done;
      tslp_pkg::S_MEAS_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = tslp_pkg::DIV_MEAS;
      end
      tslp_pkg::S_MEAS_WAIT:   cmd.meas_cap = stat.div_done;
      tslp_pkg::S_SMOOTH_PREP: cmd.smooth_prep = 1'b1;
      // divide by 100 is a reciprocal multiply in the datapath
      tslp_pkg::S_SMOOTH_GO:   cmd.tempo_cap = 1'b1;
      tslp_pkg::S_SEL_SPEED:   cmd.speed_free = !stat.sync_path;
      tslp_pkg::S_MUL1:        cmd.mul1 = 1'b1;
      tslp_pkg::S_MUL2: begin
        cmd.mul2       = 1'b1;
        cmd.speed_zero = stat.den_zero;
      end
      tslp_pkg::S_SPEED_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = tslp_pkg::DIV_SPEED;
      end
      tslp_pkg::S_SPEED_WAIT:  cmd.speed_cap = stat.div_done;
      tslp_pkg::S_ACCUM:       cmd.accum = 1'b1;
      tslp_pkg::S_TAKE:        cmd.take_step = stat.take_go;
      tslp_pkg::S_EMIT:        cmd.out_load = out_free;
      default:                 cmd.load = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tslp_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != tslp_pkg::S_IDLE;
  assign out_valid = out_valid_r;

  `TSLP_ASSERT_IMP(a_div_done_in_wait, stat.div_done, state_r == tslp_pkg::S_TGT_WAIT || state_r == tslp_pkg::S_MEAS_WAIT || state_r == tslp_pkg::S_SPEED_WAIT, "divider finished outside a wait state")
  `TSLP_ASSERT_NXT(a_accept_moves_on, state_r == tslp_pkg::S_IDLE && in_valid, state_r == tslp_pkg::S_FRONT || state_r == tslp_pkg::S_EMIT, "accepted word did not start processing")

endmodule

`default_nettype wire

/* rtl/core/tslp_dp.sv */
// playhead datapath: tempo, speed, accumulator, frame counting, fades, result register
`default_nettype none

`include "tempo_synced_loop_playhead_defines.svh"

module tslp_dp #(
  parameter int MAX_FRAMES_PER_TICK = tslp_pkg::MAX_FRAMES_DEF,
  parameter int COUNT_BITS          = tslp_pkg::COUNT_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tslp_pkg::cfg_t      cfg,
  input  wire tslp_pkg::in_item_t  in_data,
  input  wire tslp_pkg::cmd_t      cmd,
  output tslp_pkg::status_t        stat,
  output tslp_pkg::out_item_t      out_data
);

  localparam int FB     = tslp_pkg::FRAME_BITS;
  localparam int TB     = tslp_pkg::TEMPO_BITS;
  localparam int TAKE_W = $clog2(MAX_FRAMES_PER_TICK + 1);

  // playhead state
  logic                  clk_was_r, clk_was_nxt;
  logic                  trig_was_r, trig_was_nxt;
  logic [COUNT_BITS-1:0] ticks_r, ticks_nxt;
  logic                  clk_seen_r, clk_seen_nxt;
  logic [TB-1:0]         tempo_r, tempo_nxt;
  logic                  rst_wait_r, rst_wait_nxt;
  logic [31:0]           acc_r, acc_nxt;
  logic [FB-1:0]         ph_r, ph_nxt;
  logic                  cue_was_r, cue_was_nxt;
  logic                  fade_in_r, fade_in_nxt;
  logic                  fade_out_r, fade_out_nxt;
  logic                  cue_act_r, cue_act_nxt;
  logic [15:0]           gain_r, gain_nxt;

  // per-word working registers
  tslp_pkg::in_item_t    item_r, item_nxt;
  logic                  meas_ok_r, meas_ok_nxt;
  logic [7:0]            bars_r, bars_nxt;
  logic [2:0]            beat_r, beat_nxt;
  logic [16:0]           spd_r, spd_nxt;
  logic [11:0]           avail_r, avail_nxt;
  logic [TAKE_W-1:0]     taken_r, taken_nxt;
  logic                  seek_r, seek_nxt;
  logic [FB-1:0]         seek_fr_r, seek_fr_nxt;
  logic [COUNT_BITS-1:0] c_r, c_nxt;
  logic [25:0]           br_r, br_nxt;
  logic [30:0]           tgt_num_r, tgt_num_nxt;
  logic [48:0]           free_prod_r, free_prod_nxt;
  logic [40:0]           meas_num_r, meas_num_nxt;
  logic [39:0]           den_r, den_nxt;
  logic [31:0]           free_spd_r, free_spd_nxt;
  logic [FB-1:0]         tgt_r, tgt_nxt;
  logic [31:0]           meas_r, meas_nxt;
  logic [31:0]           sm_num_r, sm_num_nxt;
  logic [52:0]           tt_r, tt_nxt;
  logic [69:0]           spd_num_r, spd_num_nxt;
  logic [31:0]           speed_r, speed_nxt;
  tslp_pkg::out_item_t   out_r, out_nxt;

  logic                           div_done;
  logic [tslp_pkg::DIV_Q_W-1:0]   div_q;
  logic [tslp_pkg::DIV_NUM_W-1:0] div_num;
  logic [tslp_pkg::DIV_DEN_W-1:0] div_den;

  always_comb begin
    unique case (cmd.div_sel)
      tslp_pkg::DIV_TGT: begin
        div_num = tslp_pkg::DIV_NUM_W'(tgt_num_r);
        div_den = tslp_pkg::DIV_DEN_W'(bars_r);
      end
      tslp_pkg::DIV_MEAS: begin
        div_num = tslp_pkg::DIV_NUM_W'(meas_num_r);
        div_den = tslp_pkg::DIV_DEN_W'(c_r);
      end
      tslp_pkg::DIV_SPEED: begin
        div_num = tslp_pkg::DIV_NUM_W'(spd_num_r);
        div_den = den_r;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  tslp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  always_comb begin
    logic               rw;
    logic               ci;
    logic               co;
    logic               ca;
    logic signed [17:0] g;
    logic               edge_seen;
    logic [7:0]         b;
    logic [3:0]         bt;
    logic [16:0]        sp;
    logic [32:0]        sum;
    logic [FB:0]        ph1;
    logic [63:0]        sm_prod;

    clk_was_nxt  = clk_was_r;
    trig_was_nxt = trig_was_r;
    ticks_nxt    = ticks_r;
    clk_seen_nxt = clk_seen_r;
    tempo_nxt    = tempo_r;
    rst_wait_nxt = rst_wait_r;
    acc_nxt      = acc_r;
    ph_nxt       = ph_r;
    cue_was_nxt  = cue_was_r;
    fade_in_nxt  = fade_in_r;
    fade_out_nxt = fade_out_r;
    cue_act_nxt  = cue_act_r;
    gain_nxt     = gain_r;

    item_nxt      = item_r;
    meas_ok_nxt   = meas_ok_r;
    bars_nxt      = bars_r;
    beat_nxt      = beat_r;
    spd_nxt       = spd_r;
    avail_nxt     = avail_r;
    taken_nxt     = taken_r;
    seek_nxt      = seek_r;
    seek_fr_nxt   = seek_fr_r;
    c_nxt         = c_r;
    br_nxt        = br_r;
    tgt_num_nxt   = tgt_num_r;
    free_prod_nxt = free_prod_r;
    meas_num_nxt  = meas_num_r;
    den_nxt       = den_r;
    free_spd_nxt  = free_spd_r;
    tgt_nxt       = tgt_r;
    meas_nxt      = meas_r;
    sm_num_nxt    = sm_num_r;
    tt_nxt        = tt_r;
    spd_num_nxt   = spd_num_r;
    speed_nxt     = speed_r;
    out_nxt       = out_r;

    rw        = 1'b0;
    ci        = 1'b0;
    co        = 1'b0;
    ca        = 1'b0;
    g         = '0;
    edge_seen = 1'b0;
    b         = '0;
    bt        = '0;
    sp        = '0;
    sum       = '0;
    ph1       = '0;
    sm_prod   = '0;

    if (cmd.load) begin
      item_nxt = in_data;
    end

    if (cmd.front) begin
      rw = rst_wait_r | item_r.reset_pressed | (item_r.trigger_high & ~trig_was_r);
      trig_was_nxt = item_r.trigger_high;

      // cue crossfade
      ci = fade_in_r;
      co = fade_out_r;
      ca = cue_act_r;
      g  = $signed({2'b00, gain_r});
      if (item_r.cue_switch != cue_was_r) begin
        if (!item_r.cue_switch) begin
          ca = 1'b0;
          g  = '0;
          ci = 1'b1;
        end else begin
          co = 1'b1;
          ci = 1'b0;
        end
      end
      cue_was_nxt = item_r.cue_switch;
      if (ci) begin
        g = g + $signed({2'b00, cfg.fade_in_step});
        if (g >= $signed({2'b00, tslp_pkg::UNITY})) begin
          g  = $signed({2'b00, tslp_pkg::UNITY});
          ci = 1'b0;
        end
      end
      if (co) begin
        g = g - $signed({2'b00, cfg.fade_out_step});
        if (g <= 18'sd0) begin
          g  = '0;
          co = 1'b0;
          ca = 1'b1;
        end
      end
      fade_in_nxt  = ci;
      fade_out_nxt = co;
      cue_act_nxt  = ca;
      gain_nxt     = g[15:0];

      // clock edge: period capture and pending reset
      edge_seen   = item_r.clock_high & ~clk_was_r;
      meas_ok_nxt = edge_seen & clk_seen_r & (ticks_r != '0);
      c_nxt       = ticks_r;
      seek_nxt    = 1'b0;
      seek_fr_nxt = '0;
      if (edge_seen) begin
        clk_seen_nxt = 1'b1;
        ticks_nxt    = COUNT_BITS'(1);
        if (rw) begin
          seek_nxt = 1'b1;
          ph_nxt   = '0;
          acc_nxt  = '0;
          rw       = 1'b0;
        end
      end else if (ticks_r != '1) begin
        ticks_nxt = ticks_r + COUNT_BITS'(1);
      end
      rst_wait_nxt = rw;
      clk_was_nxt  = item_r.clock_high;

      b = 8'(item_r.bars_knob);
      if (b == 8'd0) begin
        b = cfg.fallback_bars;
      end
      if (b == 8'd0) begin
        b = 8'd4;
      end
      bars_nxt = b;

      bt = item_r.shift_beat;
      if (bt < 4'd1) begin
        bt = 4'd1;
      end
      if (bt > 4'd8) begin
        bt = 4'd8;
      end
      beat_nxt = 3'(bt - 4'd1);

      sp = item_r.speed_factor;
      if (sp < 17'd4096) begin
        sp = 17'd4096;
      end
      if (sp > 17'd65536) begin
        sp = 17'd65536;
      end
      spd_nxt = sp;

      avail_nxt = item_r.frames_ready;
      taken_nxt = '0;
    end

    if (cmd.prep) begin
      br_nxt        = 26'(bars_r) * 26'(cfg.output_rate);
      tgt_num_nxt   = 31'(beat_r) * 31'(cfg.loop_length);
      free_prod_nxt = 49'(cfg.rate_ratio) * 49'(spd_r);
      // 60 * rate * 65536 plus half the period, for round to nearest
      meas_num_nxt  = {(24'({cfg.output_rate, 6'b0}) - 24'({cfg.output_rate, 2'b0})), 16'b0}
                      + 41'(c_r >> 1);
    end

    if (cmd.prep2) begin
      den_nxt      = {40'({br_r, 8'b0}) - 40'({br_r, 4'b0})} << 6;
      free_spd_nxt = (free_prod_r[48:46] != 3'b0) ? '1 : free_prod_r[45:14];
    end

    if (cmd.tgt_cap) begin
      tgt_nxt = (div_q >= 32'(cfg.loop_length)) ? '0 : div_q[FB-1:0];
    end

    if (cmd.meas_cap) begin
      meas_nxt = div_q;
    end

    // tempo stays below 400 bpm and the sum is only used when the measure is in range, so it fits 32 bits
    if (cmd.smooth_prep) begin
      sm_num_nxt = 32'(tempo_r) * 32'd85 + meas_r * 32'd15 + 32'd50;
    end

    if (cmd.tempo_cap) begin
      sm_prod   = 64'(sm_num_r) * 64'(tslp_pkg::DIV100_MAGIC);
      tempo_nxt = sm_prod[TB+36:37];
    end

    if (cmd.speed_free) begin
      speed_nxt = free_spd_r;
    end

    if (cmd.mul1) begin
      tt_nxt = 53'(cfg.loop_length) * 53'(tempo_r);
    end

    if (cmd.mul2) begin
      spd_num_nxt = 70'(tt_r) * 70'(spd_r);
    end

    if (cmd.speed_zero) begin
      speed_nxt = '0;
    end

    if (cmd.speed_cap) begin
      speed_nxt = div_q;
    end

    if (cmd.accum) begin
      sum     = {1'b0, acc_r} + {1'b0, speed_r};
      acc_nxt = sum[32] ? '1 : sum[31:0];
    end

    if (cmd.take_step) begin
      avail_nxt = avail_r - 12'd1;
      taken_nxt = taken_r + TAKE_W'(1);
      acc_nxt   = acc_r - 32'h0100_0000;
      ph1       = {1'b0, ph_r} + (FB+1)'(1);
      // loop end: jump to the beat-shift offset
      if (ph1 >= {1'b0, cfg.loop_length}) begin
        seek_nxt    = 1'b1;
        seek_fr_nxt = tgt_r;
        ph_nxt      = tgt_r;
        acc_nxt     = '0;
      end else begin
        ph_nxt = ph1[FB-1:0];
      end
    end

    if (cmd.out_load) begin
      if (cfg.loop_length == '0) begin
        out_nxt       = '0;
        out_nxt.muted = 1'b1;
      end else begin
        out_nxt.frames_to_take = 5'(taken_r);
        out_nxt.seek_now       = seek_r;
        out_nxt.seek_frame     = seek_fr_r;
        out_nxt.play_frame     = ph_r;
        out_nxt.out_gain       = gain_r;
        out_nxt.route_to_cue   = cue_act_r;
        out_nxt.muted          = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clk_was_r  <= 1'b0;
      trig_was_r <= 1'b0;
      ticks_r    <= '0;
      clk_seen_r <= 1'b0;
      tempo_r    <= tslp_pkg::TEMPO_RESET;
      rst_wait_r <= 1'b0;
      acc_r      <= '0;
      ph_r       <= '0;
      cue_was_r  <= 1'b0;
      fade_in_r  <= 1'b0;
      fade_out_r <= 1'b0;
      cue_act_r  <= 1'b0;
      gain_r     <= tslp_pkg::UNITY;
    end else begin
      clk_was_r  <= clk_was_nxt;
      trig_was_r <= trig_was_nxt;
      ticks_r    <= ticks_nxt;
      clk_seen_r <= clk_seen_nxt;
      tempo_r    <= tempo_nxt;
      rst_wait_r <= rst_wait_nxt;
      acc_r      <= acc_nxt;
      ph_r       <= ph_nxt;
      cue_was_r  <= cue_was_nxt;
      fade_in_r  <= fade_in_nxt;
      fade_out_r <= fade_out_nxt;
      cue_act_r  <= cue_act_nxt;
      gain_r     <= gain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r      <= item_nxt;
    meas_ok_r   <= meas_ok_nxt;
    bars_r      <= bars_nxt;
    beat_r      <= beat_nxt;
    spd_r       <= spd_nxt;
    avail_r     <= avail_nxt;
    taken_r     <= taken_nxt;
    seek_r      <= seek_nxt;
    seek_fr_r   <= seek_fr_nxt;
    c_r         <= c_nxt;
    br_r        <= br_nxt;
    tgt_num_r   <= tgt_num_nxt;
    free_prod_r <= free_prod_nxt;
    meas_num_r  <= meas_num_nxt;
    den_r       <= den_nxt;
    free_spd_r  <= free_spd_nxt;
    tgt_r       <= tgt_nxt;
    meas_r      <= meas_nxt;
    sm_num_r    <= sm_num_nxt;
    tt_r        <= tt_nxt;
    spd_num_r   <= spd_num_nxt;
    speed_r     <= speed_nxt;
    out_r       <= out_nxt;
  end

  assign stat.muted     = cfg.loop_length == '0;
  assign stat.meas_ok   = meas_ok_r;
  assign stat.in_range  = (meas_r > tslp_pkg::MEAS_LO) && (meas_r < tslp_pkg::MEAS_HI);
  assign stat.sync_path = item_r.sync_switch & clk_seen_r;
  assign stat.den_zero  = den_r == '0;
  assign stat.take_go   = (acc_r[31:24] != 8'd0) && (avail_r != 12'd0)
                          && (taken_r < TAKE_W'(MAX_FRAMES_PER_TICK));
  assign stat.div_done  = div_done;

  assign out_data = out_r;

  `TSLP_ASSERT_ALW(a_gain_in_range, gain_r <= tslp_pkg::UNITY, "fade gain above unity")
  `TSLP_ASSERT_IMP(a_take_bounded, cmd.take_step, taken_r < TAKE_W'(MAX_FRAMES_PER_TICK) && avail_r != 12'd0, "frame taken past the per-tick limit")

endmodule

`default_nettype wire
